// ===== rtl/core/rsf_pkg.sv =====
package rsf_pkg;

    // Default geometry of one report
    localparam int PAYLOAD_PER_REPORT_DEF = 56;
    localparam int REPORT_BYTES_DEF       = 64;

    // Byte index within a report; covers the largest report size of 64
    localparam int IDX_W = 6;

    // Fixed header bytes
    localparam logic [7:0]       REPORT_ID = 8'h02;
    localparam logic [IDX_W-1:0] ID_POS    = IDX_W'(0);
    localparam logic [IDX_W-1:0] LEN_POS   = IDX_W'(1);

    // One generated report byte plus the sequencer's next state
    typedef struct packed {
        logic [7:0]       report_byte;
        logic             report_end;
        logic [IDX_W-1:0] idx_next;
        logic             closing_next;
        logic             item_done;
    } gen_t;

endpackage

// ===== rtl/core/rsf_byte_gen.sv =====
module rsf_byte_gen #(
    parameter int PAYLOAD_PER_REPORT = rsf_pkg::PAYLOAD_PER_REPORT_DEF,
    parameter int REPORT_BYTES       = rsf_pkg::REPORT_BYTES_DEF
) (
    input  logic [rsf_pkg::IDX_W-1:0] idx,
    input  logic                      closing,
    input  logic [7:0]                data_byte,
    input  logic [15:0]               bytes_after,
    output rsf_pkg::gen_t             gen
);
    import rsf_pkg::*;

    // Payload capacity, limited so header, payload and last byte always fit
    localparam int               CAP      = (PAYLOAD_PER_REPORT < REPORT_BYTES - 3) ?
                                            PAYLOAD_PER_REPORT : REPORT_BYTES - 3;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REPORT_BYTES - 1);
    localparam logic [IDX_W:0]   CLOSE_AT = (IDX_W+1)'(CAP + 1);
    localparam logic [7:0]       CAP_BYTE = 8'(CAP);
    localparam logic [15:0]      CAP_CNT  = 16'(CAP);

    // Next report byte for the held item at byte index idx
    always_comb
    begin
        gen              = '0;
        gen.idx_next     = idx + 1'b1;
        gen.closing_next = closing;
        if (closing)
        begin
            if (idx == LAST_IDX)
            begin
                // continuation flag closes the report
                gen.report_byte  = {7'd0, (bytes_after != 16'd0)};
                gen.report_end   = 1'b1;
                gen.idx_next     = '0;
                gen.closing_next = 1'b0;
                gen.item_done    = 1'b1;
            end
            else
            begin
                gen.report_byte = 8'h00;
            end
        end
        else if (idx == ID_POS)
        begin
            gen.report_byte = REPORT_ID;
        end
        else if (idx == LEN_POS)
        begin
            gen.report_byte = (bytes_after < CAP_CNT) ? bytes_after[7:0] + 8'd1 : CAP_BYTE;
        end
        else
        begin
            // payload byte; idx - 1 payload bytes placed, counting this one
            gen.report_byte = data_byte;
            if (({1'b0, idx} >= CLOSE_AT) || (bytes_after == 16'd0))
                gen.closing_next = 1'b1;
            else
                gen.item_done = 1'b1;
        end
    end

endmodule

// ===== rtl/core/report_segmenting_framer.sv =====
// Report segmenting framer. Each transfer on the item channel carries one
// message byte and the count of message bytes that follow it; the block
// emits 64-byte reports (id 0x02, length, payload, zero pad, continuation
// flag) on the report channel, one report byte per cycle while the output
// register can take it, report_end marking the last byte. An item yields its
// payload byte in mid report, is preceded by the id and length bytes when it
// opens a report, and is followed by the padding and flag when it closes one;
// the report byte sequencer produces these bytes into the output register.
// One item waits in the input register, so the next item is taken in the
// cycle its predecessor's last byte moves to the output register.
module report_segmenting_framer #(
    parameter int PAYLOAD_PER_REPORT = rsf_pkg::PAYLOAD_PER_REPORT_DEF,
    parameter int REPORT_BYTES       = rsf_pkg::REPORT_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [7:0]  data_byte,
    input  logic [15:0] bytes_after,
    output logic        report_valid,
    input  logic        report_ready,
    output logic [7:0]  report_byte,
    output logic        report_end
);
    import rsf_pkg::*;

    logic             a_valid_reg;
    logic [7:0]       a_data_reg;
    logic [15:0]      a_after_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             closing_reg;
    logic             o_valid_reg;
    logic [7:0]       o_byte_reg;
    logic             o_end_reg;
    gen_t             gen;
    logic             step;
    logic             pop;

    rsf_byte_gen #(
        .PAYLOAD_PER_REPORT (PAYLOAD_PER_REPORT),
        .REPORT_BYTES       (REPORT_BYTES)
    ) u_gen (
        .idx         (idx_reg),
        .closing     (closing_reg),
        .data_byte   (a_data_reg),
        .bytes_after (a_after_reg),
        .gen         (gen)
    );

    // One report byte per cycle while an item is held and the output register can take it
    assign step       = a_valid_reg && (!o_valid_reg || report_ready);
    assign pop        = step && gen.item_done;
    assign item_ready = !a_valid_reg || pop;

    // Input item register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (item_ready)
            a_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            a_data_reg  <= data_byte;
            a_after_reg <= bytes_after;
        end
    end

    // Position within the open report
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            closing_reg <= 1'b0;
        end
        else if (step)
        begin
            idx_reg     <= gen.idx_next;
            closing_reg <= gen.closing_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (step)
            o_valid_reg <= 1'b1;
        else if (report_ready)
            o_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            o_byte_reg <= gen.report_byte;
            o_end_reg  <= gen.report_end;
        end
    end

    assign report_valid = o_valid_reg;
    assign report_byte  = o_byte_reg;
    assign report_end   = o_end_reg;

    // Checks
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_W'(REPORT_BYTES - 1))
        else $error("report index past last byte");

    a_end_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (report_valid && report_end) |-> (report_byte[7:1] == 7'd0))
        else $error("last report byte is not a flag");

    a_end_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (step && gen.report_end) |=> (idx_reg == '0 && !closing_reg))
        else $error("report did not restart after last byte");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> a_valid_reg)
        else $error("input stalled with no item held");

endmodule
